>>> src/cii_pkg.sv
// ----------------------------------------------------------------------------
// cii_pkg
// shared types and constants of the complex image interpolator
// ----------------------------------------------------------------------------
package cii_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COORD_W  = 19;
  localparam int unsigned INDEX_W  = 16;
  localparam int unsigned DIM_W    = 9;
  localparam int unsigned PIXEL_W  = 32;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic                    is_write;
    logic                    outside;
    logic [INDEX_W-1:0]      addr;
    logic [PIXEL_W-1:0]      wdata;
  } cii_cmd_t;

endpackage

>>> src/cii_front.sv
// ----------------------------------------------------------------------------
// cii_front
// accepts items, rounds or floors the coordinate and computes the store address
// ----------------------------------------------------------------------------
module cii_front #(
  parameter int unsigned FRAC_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  logic [cii_pkg::INDEX_W-1:0]     in_pixel_index,
  input  logic signed [cii_pkg::SAMPLE_W-1:0] in_sample_real,
  input  logic signed [cii_pkg::SAMPLE_W-1:0] in_sample_imag,
  input  logic signed [cii_pkg::COORD_W-1:0]  in_coord_x,
  input  logic signed [cii_pkg::COORD_W-1:0]  in_coord_y,
  input  logic [cii_pkg::DIM_W-1:0]       width,
  input  logic [cii_pkg::DIM_W-1:0]       height,
  input  logic                            mode,
  output logic                            cmd_valid,
  input  logic                            cmd_ready,
  output cii_pkg::cii_cmd_t               cmd,
  output logic [FRAC_BITS-1:0]            cmd_dr,
  output logic [FRAC_BITS-1:0]            cmd_da,
  output logic                            cmd_bilinear
);
  import cii_pkg::*;

  localparam int unsigned IW = COORD_W - FRAC_BITS + 1;
  localparam logic signed [COORD_W:0] HALF = (COORD_W+1)'(1) <<< (FRAC_BITS - 1);

  logic signed [COORD_W:0] xs, ys;
  logic signed [IW-1:0] ci, ri;
  logic signed [IW+1:0] lim_w, lim_h;
  logic out_n;
  logic [IW+DIM_W:0] prod;
  logic valid_r;
  cii_cmd_t cmd_r, cmd_nxt;
  logic [FRAC_BITS-1:0] dr_r, da_r;
  logic bil_r;

  assign in_ready = !valid_r || cmd_ready;

  always_comb begin
    xs = {in_coord_x[COORD_W-1], in_coord_x};
    ys = {in_coord_y[COORD_W-1], in_coord_y};
    if (mode == MODE_NEAREST) begin
      xs = xs + HALF;
      ys = ys + HALF;
      // truncate toward zero: values of -1 and below stay negative, values between -1 and 0 become 0
      ci = xs[COORD_W:FRAC_BITS];
      ri = ys[COORD_W:FRAC_BITS];
      if (xs < 0 && xs[FRAC_BITS-1:0] != '0) ci = ci + IW'(1);
      if (ys < 0 && ys[FRAC_BITS-1:0] != '0) ri = ri + IW'(1);
      lim_w = (IW+2)'(width);
      lim_h = (IW+2)'(height);
    end else begin
      ci = xs[COORD_W:FRAC_BITS];
      ri = ys[COORD_W:FRAC_BITS];
      lim_w = (IW+2)'(width) - (IW+2)'(1);
      lim_h = (IW+2)'(height) - (IW+2)'(1);
    end
    out_n = ci[IW-1] || ri[IW-1] || ((IW+2)'(ci) >= lim_w) || ((IW+2)'(ri) >= lim_h);
    prod = (IW+DIM_W+1)'(ri[IW-2:0]) * (IW+DIM_W+1)'(width) + (IW+DIM_W+1)'(ci[IW-2:0]);
    cmd_nxt.is_write = (in_op == OP_WRITE);
    cmd_nxt.outside  = out_n;
    cmd_nxt.addr     = (in_op == OP_WRITE) ? in_pixel_index : prod[INDEX_W-1:0];
    cmd_nxt.wdata    = {in_sample_imag, in_sample_real};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      cmd_r <= cmd_nxt;
      dr_r  <= in_coord_x[FRAC_BITS-1:0];
      da_r  <= in_coord_y[FRAC_BITS-1:0];
      bil_r <= (mode == MODE_BILINEAR);
    end
  end

  assign cmd_valid    = valid_r;
  assign cmd          = cmd_r;
  assign cmd_dr       = dr_r;
  assign cmd_da       = da_r;
  assign cmd_bilinear = bil_r;

endmodule

>>> src/cii_back.sv
// ----------------------------------------------------------------------------
// cii_back
// image store, four-neighbor read and weighted sum with rounding
// ----------------------------------------------------------------------------
module cii_back #(
  parameter int unsigned FRAC_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_valid,
  output logic                            cmd_ready,
  input  cii_pkg::cii_cmd_t               cmd,
  input  logic [FRAC_BITS-1:0]            cmd_dr,
  input  logic [FRAC_BITS-1:0]            cmd_da,
  input  logic                            cmd_bilinear,
  input  logic [cii_pkg::DIM_W-1:0]       width,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [cii_pkg::SAMPLE_W-1:0] out_real,
  output logic signed [cii_pkg::SAMPLE_W-1:0] out_imag,
  output logic                            out_outside,
  output logic                            out_clipped
);
  import cii_pkg::*;

  localparam int unsigned DEPTH = 1 << INDEX_W;
  localparam int unsigned WW = FRAC_BITS + 1;
  localparam int unsigned PW = SAMPLE_W + 2 * FRAC_BITS + 3;

  // four copies give four reads per cycle
  logic [PIXEL_W-1:0] mem0 [DEPTH];
  logic [PIXEL_W-1:0] mem1 [DEPTH];
  logic [PIXEL_W-1:0] mem2 [DEPTH];
  logic [PIXEL_W-1:0] mem3 [DEPTH];

  logic adv;
  logic s1_v, s2_v, s3_v, s4_v;
  logic s1_o, s2_o, s3_o;
  logic s1_b, s2_b, s3_b;
  logic [FRAC_BITS-1:0] s1_dr, s1_da;
  logic [PIXEL_W-1:0] q00, q01, q10, q11;
  logic [PIXEL_W-1:0] s2_q00, s2_q01, s2_q10, s2_q11;
  logic [INDEX_W-1:0] a01, a10, a11;
  logic [WW-1:0] w_dr, w_da, w_ndr, w_nda;
  logic [2*WW-1:0] w00, w01, w10, w11;
  logic signed [PW-1:0] t_re [4];
  logic signed [PW-1:0] t_im [4];
  logic signed [PW-1:0] sum_re, sum_im;
  logic signed [SAMPLE_W-1:0] s2_nre, s2_nim;
  logic signed [SAMPLE_W-1:0] s3_nre, s3_nim;
  logic signed [SAMPLE_W-1:0] r_re, r_im;
  logic c_re, c_im;
  logic signed [SAMPLE_W-1:0] o_re_r, o_im_r;
  logic o_out_r, o_clp_r;

  function automatic logic signed [SAMPLE_W:0] rnd(input logic signed [PW-1:0] t);
    logic signed [PW-1:0] v;
    logic [PW-1:0] m;
    logic signed [PW-1:0] q;
    v = t + (PW'(1) <<< (2 * FRAC_BITS - 1));
    m = v[PW-1] ? PW'(-v) : PW'(v);
    q = PW'(m >> (2 * FRAC_BITS));
    q = v[PW-1] ? -q : q;
    if (q > PW'(32767)) rnd = {1'b1, 16'sh7fff};
    else if (q < -PW'(32768)) rnd = {1'b1, 16'sh8000};
    else rnd = {1'b0, q[SAMPLE_W-1:0]};
  endfunction

  assign adv = !s4_v || out_ready;
  assign cmd_ready = adv;

  assign a01 = cmd.addr + INDEX_W'(1);
  assign a10 = cmd.addr + INDEX_W'(width);
  assign a11 = cmd.addr + INDEX_W'(width) + INDEX_W'(1);

  always_ff @(posedge clk) begin
    if (cmd_valid && adv && cmd.is_write) begin
      mem0[cmd.addr] <= cmd.wdata;
      mem1[cmd.addr] <= cmd.wdata;
      mem2[cmd.addr] <= cmd.wdata;
      mem3[cmd.addr] <= cmd.wdata;
    end
    if (adv) begin
      q00 <= mem0[cmd.addr];
      q01 <= mem1[a01];
      q10 <= mem2[a10];
      q11 <= mem3[a11];
    end
  end

  always_comb begin
    w_dr  = WW'(s1_dr);
    w_da  = WW'(s1_da);
    w_ndr = (WW'(1) << FRAC_BITS) - w_dr;
    w_nda = (WW'(1) << FRAC_BITS) - w_da;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else if (adv) begin
      s1_v <= cmd_valid && !cmd.is_write;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
    if (adv) begin
      s1_o  <= cmd.outside;
      s1_b  <= cmd_bilinear;
      s1_dr <= cmd_dr;
      s1_da <= cmd_da;
      s2_o  <= s1_o;
      s2_b  <= s1_b;
      s2_nre <= q00[SAMPLE_W-1:0];
      s2_nim <= q00[PIXEL_W-1:SAMPLE_W];
      w00 <= w_nda * w_ndr;
      w10 <= w_da * w_ndr;
      w01 <= w_nda * w_dr;
      w11 <= w_da * w_dr;
      s3_o <= s2_o;
      s3_b <= s2_b;
      t_re[0] <= PW'($signed(s2_q00[SAMPLE_W-1:0])) * $signed({1'b0, w00});
      t_re[1] <= PW'($signed(s2_q01[SAMPLE_W-1:0])) * $signed({1'b0, w01});
      t_re[2] <= PW'($signed(s2_q10[SAMPLE_W-1:0])) * $signed({1'b0, w10});
      t_re[3] <= PW'($signed(s2_q11[SAMPLE_W-1:0])) * $signed({1'b0, w11});
      t_im[0] <= PW'($signed(s2_q00[PIXEL_W-1:SAMPLE_W])) * $signed({1'b0, w00});
      t_im[1] <= PW'($signed(s2_q01[PIXEL_W-1:SAMPLE_W])) * $signed({1'b0, w01});
      t_im[2] <= PW'($signed(s2_q10[PIXEL_W-1:SAMPLE_W])) * $signed({1'b0, w10});
      t_im[3] <= PW'($signed(s2_q11[PIXEL_W-1:SAMPLE_W])) * $signed({1'b0, w11});
      s3_nre <= s2_nre;
      s3_nim <= s2_nim;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_q00 <= q00;
      s2_q01 <= q01;
      s2_q10 <= q10;
      s2_q11 <= q11;
    end
  end

  always_comb begin
    sum_re = t_re[0] + t_re[1] + t_re[2] + t_re[3];
    sum_im = t_im[0] + t_im[1] + t_im[2] + t_im[3];
    {c_re, r_re} = rnd(sum_re);
    {c_im, r_im} = rnd(sum_im);
  end

  always_ff @(posedge clk) begin
    if (adv && s3_v) begin
      if (s3_o) begin
        o_re_r  <= '0;
        o_im_r  <= '0;
        o_out_r <= 1'b1;
        o_clp_r <= 1'b0;
      end else if (s3_b) begin
        o_re_r  <= r_re;
        o_im_r  <= r_im;
        o_out_r <= 1'b0;
        o_clp_r <= c_re || c_im;
      end else begin
        o_re_r  <= s3_nre;
        o_im_r  <= s3_nim;
        o_out_r <= 1'b0;
        o_clp_r <= 1'b0;
      end
    end
  end

  assign out_valid   = s4_v;
  assign out_real    = o_re_r;
  assign out_imag    = o_im_r;
  assign out_outside = o_out_r;
  assign out_clipped = o_clp_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_real))
    else $error("result changed while stalled");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outside |-> out_real == '0 && !out_clipped)
    else $error("outside result not zero");
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s3_v))
    else $error("pipeline moved during stall");

endmodule

>>> src/complex_image_interpolator_top.sv
// ----------------------------------------------------------------------------
// complex_image_interpolator_top
// complex int16 image store with nearest and bilinear lookup
// ----------------------------------------------------------------------------
// One item per cycle is accepted while the result side keeps up; a waiting
// result halts the whole back pipeline and, through it, the input. A query's
// result passes the front command register, the registered store read, the
// weight multiply, the four-term product stage and the rounded output
// register. Pixel writes give no result. The store holds four copies so that
// all four neighbors are read together.
module complex_image_interpolator_top #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned FRAC_BITS  = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  logic [cii_pkg::INDEX_W-1:0]     in_pixel_index,
  input  logic signed [cii_pkg::SAMPLE_W-1:0] in_sample_real,
  input  logic signed [cii_pkg::SAMPLE_W-1:0] in_sample_imag,
  input  logic signed [cii_pkg::COORD_W-1:0]  in_coord_x,
  input  logic signed [cii_pkg::COORD_W-1:0]  in_coord_y,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [cii_pkg::SAMPLE_W-1:0] out_real,
  output logic signed [cii_pkg::SAMPLE_W-1:0] out_imag,
  output logic                            out_outside,
  output logic                            out_clipped,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [3:0]                      cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import cii_pkg::*;

  logic mode_r;
  logic [DIM_W-1:0] width_r, height_r;
  logic [DIM_W-1:0] wclamp, hclamp;
  logic wr;
  logic cmd_valid, cmd_ready, cmd_bil;
  cii_cmd_t cmd;
  logic [FRAC_BITS-1:0] cmd_dr, cmd_da;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    wclamp = cfg_pwdata[DIM_W-1:0];
    if (wclamp == '0) wclamp = DIM_W'(1);
    else if (32'(wclamp) > MAX_WIDTH) wclamp = DIM_W'(MAX_WIDTH);
    hclamp = cfg_pwdata[DIM_W-1:0];
    if (hclamp == '0) hclamp = DIM_W'(1);
    else if (32'(hclamp) > MAX_HEIGHT) hclamp = DIM_W'(MAX_HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_BILINEAR;
      width_r  <= (MAX_WIDTH < 256) ? DIM_W'(MAX_WIDTH) : DIM_W'(256);
      height_r <= (MAX_HEIGHT < 256) ? DIM_W'(MAX_HEIGHT) : DIM_W'(256);
    end else if (wr) begin
      if (cfg_paddr[3:2] == REG_MODE) mode_r <= cfg_pwdata[0];
      else if (cfg_paddr[3:2] == REG_WIDTH) width_r <= wclamp;
      else if (cfg_paddr[3:2] == REG_HEIGHT) height_r <= hclamp;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[3:2] == REG_MODE) cfg_prdata = 32'(mode_r);
    else if (cfg_paddr[3:2] == REG_WIDTH) cfg_prdata = 32'(width_r);
    else if (cfg_paddr[3:2] == REG_HEIGHT) cfg_prdata = 32'(height_r);
  end

  cii_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_op, .in_pixel_index,
    .in_sample_real, .in_sample_imag, .in_coord_x, .in_coord_y,
    .width(width_r), .height(height_r), .mode(mode_r),
    .cmd_valid, .cmd_ready, .cmd, .cmd_dr, .cmd_da, .cmd_bilinear(cmd_bil)
  );

  cii_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd, .cmd_dr, .cmd_da,
    .cmd_bilinear(cmd_bil), .width(width_r),
    .out_valid, .out_ready, .out_real, .out_imag, .out_outside, .out_clipped
  );

endmodule

>>> bench/cii_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cii_checker
// watches the item, result and register ports of the interpolator, keeps a
// shadow image and register set, predicts each query result and compares it
// field by field with the block's output in order
// ----------------------------------------------------------------------------
module cii_checker #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned FRAC_BITS  = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                in_op,
  input  logic [cii_pkg::INDEX_W-1:0]         in_pixel_index,
  input  logic signed [cii_pkg::SAMPLE_W-1:0] in_sample_real,
  input  logic signed [cii_pkg::SAMPLE_W-1:0] in_sample_imag,
  input  logic signed [cii_pkg::COORD_W-1:0]  in_coord_x,
  input  logic signed [cii_pkg::COORD_W-1:0]  in_coord_y,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [cii_pkg::SAMPLE_W-1:0] out_real,
  input  logic signed [cii_pkg::SAMPLE_W-1:0] out_imag,
  input  logic                                out_outside,
  input  logic                                out_clipped,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [3:0]                          cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  input  logic                                cfg_pready,
  output int                                  errors,
  output int                                  pending
);
  import cii_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    logic                       outside;
    logic                       clipped;
  } pixel_result_t;

  localparam longint ONE = longint'(1) << FRAC_BITS;

  logic [PIXEL_W-1:0] image_shadow [0:65535];
  logic               mode_q;
  int                 width_q;
  int                 height_q;
  pixel_result_t      expected_pixels [$];

  function automatic int clamp_dim(logic [DIM_W-1:0] v, int maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic longint trunc_shift(longint v, int sh);
    if (v >= 0) return v >>> sh;
    return -((-v) >>> sh);
  endfunction

  function automatic logic [PIXEL_W-1:0] fetch(longint row, longint col);
    longint a;
    a = row * width_q + col;
    if (a < 0 || a >= 65536) return '0;
    return image_shadow[a];
  endfunction

  function automatic pixel_result_t interpolate(logic signed [COORD_W-1:0] cx,
                                                logic signed [COORD_W-1:0] cy);
    pixel_result_t      res;
    longint             x, y, i, j, dr, da, t, r;
    longint             w [4];
    logic [PIXEL_W-1:0] q [4];
    logic [PIXEL_W-1:0] px;
    res = '0;
    x = cx;
    y = cy;
    if (mode_q == MODE_NEAREST) begin
      j = trunc_shift(x + ONE / 2, FRAC_BITS);
      i = trunc_shift(y + ONE / 2, FRAC_BITS);
      if (i < 0 || i >= height_q || j < 0 || j >= width_q) begin
        res.outside = 1'b1;
      end else begin
        px = fetch(i, j);
        res.re = px[15:0];
        res.im = px[31:16];
      end
    end else begin
      dr = x & (ONE - 1);
      da = y & (ONE - 1);
      j = (x - dr) / ONE;
      i = (y - da) / ONE;
      if (i < 0 || i >= height_q - 1 || j < 0 || j >= width_q - 1) begin
        res.outside = 1'b1;
      end else begin
        q[0] = fetch(i, j);
        q[1] = fetch(i, j + 1);
        q[2] = fetch(i + 1, j);
        q[3] = fetch(i + 1, j + 1);
        w[0] = (ONE - da) * (ONE - dr);
        w[1] = (ONE - da) * dr;
        w[2] = da * (ONE - dr);
        w[3] = da * dr;
        for (int p = 0; p < 2; p++) begin
          t = 0;
          for (int k = 0; k < 4; k++) begin
            if (p == 0) t += longint'($signed(q[k][15:0])) * w[k];
            else t += longint'($signed(q[k][31:16])) * w[k];
          end
          r = trunc_shift(t + (longint'(1) << (2 * FRAC_BITS - 1)), 2 * FRAC_BITS);
          if (r > 32767) begin
            r = 32767;
            res.clipped = 1'b1;
          end
          if (r < -32768) begin
            r = -32768;
            res.clipped = 1'b1;
          end
          if (p == 0) res.re = r[15:0];
          else res.im = r[15:0];
        end
      end
    end
    return res;
  endfunction

  assign pending = expected_pixels.size();

  always @(posedge clk) begin
    pixel_result_t exp_r;
    if (!rst_n) begin
      errors    = 0;
      mode_q   <= MODE_BILINEAR;
      width_q  <= clamp_dim(DIM_W'(256), MAX_WIDTH);
      height_q <= clamp_dim(DIM_W'(256), MAX_HEIGHT);
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_MODE:   mode_q   <= cfg_pwdata[0];
          REG_WIDTH:  width_q  <= clamp_dim(cfg_pwdata[DIM_W-1:0], MAX_WIDTH);
          REG_HEIGHT: height_q <= clamp_dim(cfg_pwdata[DIM_W-1:0], MAX_HEIGHT);
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_op == OP_WRITE) begin
          image_shadow[in_pixel_index] = {in_sample_imag, in_sample_real};
        end else begin
          expected_pixels.push_back(interpolate(in_coord_x, in_coord_y));
        end
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transfer re=%0d im=%0d outside=%0b clipped=%0b",
                   $time, out_real, out_imag, out_outside, out_clipped);
        end else begin
          exp_r = expected_pixels.pop_front();
          if (out_real !== exp_r.re) begin
            errors++;
            $display("%0t: real mismatch expected %0d actual %0d", $time, exp_r.re, out_real);
          end
          if (out_imag !== exp_r.im) begin
            errors++;
            $display("%0t: imag mismatch expected %0d actual %0d", $time, exp_r.im, out_imag);
          end
          if (out_outside !== exp_r.outside) begin
            errors++;
            $display("%0t: outside mismatch expected %0b actual %0b",
                     $time, exp_r.outside, out_outside);
          end
          if (out_clipped !== exp_r.clipped) begin
            errors++;
            $display("%0t: clipped mismatch expected %0b actual %0b",
                     $time, exp_r.clipped, out_clipped);
          end
        end
      end
    end
  end

endmodule

>>> bench/tb_complex_image_interpolator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_image_interpolator_top
// drives pixel writes and nearest / bilinear queries through several image
// sizes and modes, with random gaps on both channels; every neighbor a query
// can touch is written first, and the checker compares all results
// ----------------------------------------------------------------------------
module tb_complex_image_interpolator_top;
  import cii_pkg::*;

  localparam int NUM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 155;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_op;
  logic [INDEX_W-1:0]           in_pixel_index;
  logic signed [SAMPLE_W-1:0]   in_sample_real;
  logic signed [SAMPLE_W-1:0]   in_sample_imag;
  logic signed [COORD_W-1:0]    in_coord_x;
  logic signed [COORD_W-1:0]    in_coord_y;
  logic                         out_valid;
  logic                         out_ready;
  logic signed [SAMPLE_W-1:0]   out_real;
  logic signed [SAMPLE_W-1:0]   out_imag;
  logic                         out_outside;
  logic                         out_clipped;
  logic                         cfg_psel;
  logic                         cfg_penable;
  logic                         cfg_pwrite;
  logic [3:0]                   cfg_paddr;
  logic [31:0]                  cfg_pwdata;
  logic [31:0]                  cfg_prdata;
  logic                         cfg_pready;
  int                           errors;
  int                           pending;

  bit written [0:65535];
  int img_w;
  int img_h;
  int n_items;
  int n_queries;
  bit in_quiet;
  bit out_quiet;

  complex_image_interpolator_top u_top (.*);

  cii_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_op, .in_pixel_index, .in_sample_real,
    .in_sample_imag, .in_coord_x, .in_coord_y, .out_valid, .out_ready, .out_real,
    .out_imag, .out_outside, .out_clipped, .cfg_psel, .cfg_penable, .cfg_pwrite,
    .cfg_paddr, .cfg_pwdata, .cfg_pready, .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // result side stalls
  initial begin
    int stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
        stall = out_quiet ? 0 : $urandom_range(0, 5);
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_item(logic op, logic [INDEX_W-1:0] idx, logic [15:0] re,
                           logic [15:0] im, logic [COORD_W-1:0] x,
                           logic [COORD_W-1:0] y);
    int gap;
    if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
    gap = in_quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_pixel_index <= idx;
    in_sample_real <= re;
    in_sample_imag <= im;
    in_coord_x     <= x;
    in_coord_y     <= y;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    n_items++;
    if (op == OP_WRITE) written[idx] = 1'b1;
    else n_queries++;
  endtask

  task automatic write_pixel(int idx);
    push_item(OP_WRITE, idx[15:0], 16'($urandom), 16'($urandom),
              COORD_W'($urandom), COORD_W'($urandom));
  endtask

  // writes any unwritten pixel a query at (x, y) may read, then sends the query
  task automatic send_query(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
    int fx, fy, idx;
    fx = int'(x) >>> 10;
    fy = int'(y) >>> 10;
    for (int r = fy; r <= fy + 1; r++) begin
      for (int c = fx; c <= fx + 1; c++) begin
        if (r >= 0 && r < img_h && c >= 0 && c < img_w) begin
          idx = r * img_w + c;
          if (!written[idx] || $urandom_range(0, 3) == 0) write_pixel(idx);
        end
      end
    end
    push_item(OP_QUERY, INDEX_W'($urandom), 16'($urandom), 16'($urandom), x, y);
  endtask

  task automatic apb_write(logic [1:0] reg_idx, logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic int clamp_dim(int v, int maxv);
    v = v & 32'h1ff;
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  initial begin
    int ph_mode [NUM_PHASES] = '{1, 0, 0, 1, 1, 0, 1, 0, 1, 0};
    int ph_w [NUM_PHASES] = '{256, 256, 1, 2, 0, 511, 7, 16, -1, -1};
    int ph_h [NUM_PHASES] = '{256, 256, 1, 2, 511, 0, 13, 9, -1, -1};
    int dir_x [10] = '{0, 255*1024+1023, 254*1024+1023, -262144, 262143,
                       -1, 512, -513, 511, 3*1024};
    int dir_y [10] = '{0, 0, 254*1024+1023, -262144, 262143,
                       -1, 512, 0, -512, 254*1024+512};
    int wv, hv, kind, r, c, loops;
    in_valid = 1'b0; in_op = OP_WRITE; in_pixel_index = '0;
    in_sample_real = '0; in_sample_imag = '0; in_coord_x = '0; in_coord_y = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    n_items = 0; n_queries = 0; in_quiet = 0; out_quiet = 0;
    img_w = 256; img_h = 256;
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      wv = ph_w[ph] < 0 ? $urandom_range(1, 300) : ph_w[ph];
      hv = ph_h[ph] < 0 ? $urandom_range(1, 300) : ph_h[ph];
      apb_write(REG_MODE, ph_mode[ph]);
      apb_write(REG_WIDTH, wv);
      apb_write(REG_HEIGHT, hv);
      if (ph == 0) apb_write(2'd3, 32'hffff_ffff);
      img_w = clamp_dim(wv, 256);
      img_h = clamp_dim(hv, 256);
      if (ph < 2) begin
        push_item(OP_WRITE, 16'h0000, 16'sh8000, 16'sh7fff, '0, '0);
        push_item(OP_WRITE, 16'hffff, 16'sh7fff, 16'sh8000, '1, '1);
        for (int k = 0; k < 10; k++) begin
          send_query(COORD_W'(dir_x[k]), COORD_W'(dir_y[k]));
        end
      end
      while (n_items < (ph + 1) * ITEMS_PER_PHASE) begin
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
          r = $urandom_range(0, img_h + 1) - 1;
          c = $urandom_range(0, img_w + 1) - 1;
          send_query(COORD_W'(c * 1024 + $urandom_range(0, 1023)),
                     COORD_W'(r * 1024 + $urandom_range(0, 1023)));
        end else if (kind < 85) begin
          write_pixel($urandom_range(0, img_h - 1) * img_w + $urandom_range(0, img_w - 1));
        end else if (kind < 92) begin
          write_pixel($urandom_range(0, 65535));
        end else begin
          send_query(COORD_W'($urandom), COORD_W'($urandom));
        end
      end
    end
    in_valid <= 1'b0;
    loops = 0;
    while (pending != 0 && loops < 100000) begin
      @(negedge clk);
      loops++;
    end
    repeat (20) @(negedge clk);
    $display("ran %0d items, %0d of them queries, over %0d register settings",
             n_items, n_queries, NUM_PHASES);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> complex_image_interpolator_top.f
src/cii_pkg.sv
src/cii_front.sv
src/cii_back.sv
src/complex_image_interpolator_top.sv
bench/cii_checker.sv
bench/tb_complex_image_interpolator_top.sv
